// File: design/rarc_pkg.sv
package rarc_pkg;

    // Default internal word width of the arithmetic.
    localparam int RARC_WORD_WIDTH = 32;

    // Fixed widths of the stream fields.
    localparam int RARC_FIELD_W      = 32;
    localparam int RARC_MODE_W       = 2;
    localparam int RARC_ORD_W        = 2;
    localparam int RARC_IN_TDATA_W   = 4 * RARC_FIELD_W;
    localparam int RARC_OUT_FIELDS_W = 2 * RARC_FIELD_W + RARC_ORD_W;
    localparam int RARC_OUT_TDATA_W  = ((RARC_OUT_FIELDS_W + 7) / 8) * 8;

    // Operation codes carried in the input tuser.
    localparam logic [RARC_MODE_W-1:0] MODE_REDUCE = 2'd0;
    localparam logic [RARC_MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [RARC_MODE_W-1:0] MODE_CMP    = 2'd2;

    // Compare outcomes, also used as fraction signs.
    localparam logic signed [RARC_ORD_W-1:0] ORD_EQ = 2'sd0;
    localparam logic signed [RARC_ORD_W-1:0] ORD_GT = 2'sd1;
    localparam logic signed [RARC_ORD_W-1:0] ORD_LT = -2'sd1;

    typedef enum logic [1:0] {
        IT_OP_MUL,
        IT_OP_DIV,
        IT_OP_GCD
    } t_it_op;

    typedef struct packed {
        logic   start;
        t_it_op op;
    } t_it_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_it_stat;

    typedef enum logic [2:0] {
        IT_IDLE,
        IT_MUL,
        IT_DIV,
        IT_GCD,
        IT_SHL,
        IT_DONE
    } t_it_state;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_DISPATCH,
        SQ_MUL1,
        SQ_MUL2,
        SQ_MUL3,
        SQ_RED_START,
        SQ_GCD,
        SQ_DIVN,
        SQ_DIVD,
        SQ_RED_DONE,
        SQ_CMP_START,
        SQ_CMP_M1,
        SQ_CMP_M2,
        SQ_OUT
    } t_seq_state;

endpackage

// File: design/rational_add_reduce_compare_top.sv
// One item is worked on at a time; the next input word is accepted as soon as the result has
// moved into the output register.
// Reset is synchronous and active low; it clears the sequencer and the output valid flag.
module rational_add_reduce_compare_top #(
    parameter int WORD_WIDTH = rarc_pkg::RARC_WORD_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input stream.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata, from bit 0: left_numer, left_denom, right_numer, right_denom.
    input  logic [rarc_pkg::RARC_IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser, from bit 0: mode.
    input  logic [rarc_pkg::RARC_MODE_W-1:0]      s_axis_tuser,
    // Output stream.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata, from bit 0: result_numer, result_denom, order, zero fill.
    output logic [rarc_pkg::RARC_OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser, from bit 0: invalid.
    output logic [0:0]                            m_axis_tuser
);
    import rarc_pkg::*;

    localparam int W = WORD_WIDTH;
    localparam int F = RARC_FIELD_W;

    // Input fields are sign-extended or truncated to the internal word width.
    function automatic logic [W-1:0] from_field(input logic signed [F-1:0] f);
        from_field = W'(f);
    endfunction

    // Internal words are sign-extended or truncated back to the field width.
    function automatic logic [F-1:0] to_field(input logic signed [W-1:0] p);
        to_field = F'(p);
    endfunction

    // Magnitude of a two's complement word; the most negative value keeps its bits.
    function automatic logic [W-1:0] mag(input logic [W-1:0] x);
        mag = x[W-1] ? (~x + W'(1)) : x;
    endfunction

    // Sign of a fraction as seen through the sign bits of its words.
    function automatic logic signed [RARC_ORD_W-1:0] frac_sign(input logic [W-1:0] n,
                                                             input logic [W-1:0] d);
        if (n == '0) begin
            frac_sign = ORD_EQ;
        end else if (n[W-1] ^ d[W-1]) begin
            frac_sign = ORD_LT;
        end else begin
            frac_sign = ORD_GT;
        end
    endfunction

    t_seq_state                   r_state, n_state;
    logic [RARC_MODE_W-1:0]       r_mode, n_mode;
    logic [W-1:0]                 r_ln, n_ln, r_ld, n_ld, r_rn, n_rn, r_rd, n_rd;
    logic [W-1:0]                 r_t, n_t;
    logic [W-1:0]                 r_xn, n_xn, r_xd, n_xd;
    logic [W-1:0]                 r_g, n_g;
    logic [W-1:0]                 r_qn, n_qn, r_qd, n_qd;
    logic [W-1:0]                 r_an, n_an, r_ad, n_ad;
    logic                         r_pass, n_pass;
    logic [2*W-1:0]               r_p1, n_p1;
    logic [W-1:0]                 r_res_n, n_res_n, r_res_d, n_res_d;
    logic signed [RARC_ORD_W-1:0] r_ord, n_ord;
    logic                         r_inv, n_inv;

    logic                         r_ovalid, n_ovalid;
    logic [F-1:0]                 r_on, n_on, r_od, n_od;
    logic [RARC_ORD_W-1:0]        r_oord, n_oord;
    logic                         r_oinv, n_oinv;

    t_it_cmd                      w_cmd;
    t_it_stat                     w_stat;
    logic [W-1:0]                 w_a, w_b, w_hi, w_lo;
    logic [2*W-1:0]               w_p2;
    logic signed [RARC_ORD_W-1:0] w_s1, w_s2;

    // The shared unit runs every multiply, divide and gcd of the item.
    rarc_iter #(
        .WORD_WIDTH (W)
    ) u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_stat  (w_stat),
        .o_hi    (w_hi),
        .o_lo    (w_lo)
    );

    assign w_p2 = {w_hi, w_lo};
    // Left reduced fraction sits in an/ad, right one in qn/qd during compare.
    assign w_s1 = frac_sign(r_an, r_ad);
    assign w_s2 = frac_sign(r_qn, r_qd);

    assign s_axis_tready = (r_state == SQ_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{(RARC_OUT_TDATA_W - RARC_OUT_FIELDS_W){1'b0}}, r_oord, r_od, r_on};
    assign m_axis_tuser  = r_oinv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= SQ_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_ln    <= n_ln;
        r_ld    <= n_ld;
        r_rn    <= n_rn;
        r_rd    <= n_rd;
        r_t     <= n_t;
        r_xn    <= n_xn;
        r_xd    <= n_xd;
        r_g     <= n_g;
        r_qn    <= n_qn;
        r_qd    <= n_qd;
        r_an    <= n_an;
        r_ad    <= n_ad;
        r_pass  <= n_pass;
        r_p1    <= n_p1;
        r_res_n <= n_res_n;
        r_res_d <= n_res_d;
        r_ord   <= n_ord;
        r_inv   <= n_inv;
        r_on    <= n_on;
        r_od    <= n_od;
        r_oord  <= n_oord;
        r_oinv  <= n_oinv;
    end

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_ln     = r_ln;
        n_ld     = r_ld;
        n_rn     = r_rn;
        n_rd     = r_rd;
        n_t      = r_t;
        n_xn     = r_xn;
        n_xd     = r_xd;
        n_g      = r_g;
        n_qn     = r_qn;
        n_qd     = r_qd;
        n_an     = r_an;
        n_ad     = r_ad;
        n_pass   = r_pass;
        n_p1     = r_p1;
        n_res_n  = r_res_n;
        n_res_d  = r_res_d;
        n_ord    = r_ord;
        n_inv    = r_inv;
        n_ovalid = r_ovalid;
        n_on     = r_on;
        n_od     = r_od;
        n_oord   = r_oord;
        n_oinv   = r_oinv;

        w_cmd.start = 1'b0;
        w_cmd.op    = IT_OP_MUL;
        w_a         = '0;
        w_b         = '0;

        // The output register empties when the consumer takes the word.
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            SQ_IDLE: begin
                if (s_axis_tvalid) begin
                    n_mode  = s_axis_tuser;
                    n_ln    = from_field(s_axis_tdata[0*F +: F]);
                    n_ld    = from_field(s_axis_tdata[1*F +: F]);
                    n_rn    = from_field(s_axis_tdata[2*F +: F]);
                    n_rd    = from_field(s_axis_tdata[3*F +: F]);
                    n_state = SQ_DISPATCH;
                end
            end
            SQ_DISPATCH: begin
                n_res_n = '0;
                n_res_d = '0;
                n_ord   = ORD_EQ;
                n_inv   = 1'b0;
                n_pass  = 1'b0;
                case (r_mode)
                    MODE_REDUCE: begin
                        n_xn    = r_ln;
                        n_xd    = r_ld;
                        n_state = SQ_RED_START;
                    end
                    MODE_ADD: begin
                        // Numerator first: rd*ln, then ld*rn, then the denominator ld*rd.
                        w_cmd.start = 1'b1;
                        w_cmd.op    = IT_OP_MUL;
                        w_a         = r_rd;
                        w_b         = r_ln;
                        n_state     = SQ_MUL1;
                    end
                    MODE_CMP: begin
                        if (r_ld == '0 || r_rd == '0) begin
                            n_inv   = 1'b1;
                            n_state = SQ_OUT;
                        end else begin
                            n_xn    = r_ln;
                            n_xd    = r_ld;
                            n_state = SQ_RED_START;
                        end
                    end
                    default: begin
                        // The unused mode gives a zero word flagged invalid.
                        n_inv   = 1'b1;
                        n_state = SQ_OUT;
                    end
                endcase
            end
            SQ_MUL1: begin
                if (w_stat.done) begin
                    n_t         = w_lo;
                    w_cmd.start = 1'b1;
                    w_cmd.op    = IT_OP_MUL;
                    w_a         = r_ld;
                    w_b         = r_rn;
                    n_state     = SQ_MUL2;
                end
            end
            SQ_MUL2: begin
                if (w_stat.done) begin
                    n_t         = r_t + w_lo;
                    w_cmd.start = 1'b1;
                    w_cmd.op    = IT_OP_MUL;
                    w_a         = r_rd;
                    w_b         = r_ld;
                    n_state     = SQ_MUL3;
                end
            end
            SQ_MUL3: begin
                if (w_stat.done) begin
                    n_xn    = r_t;
                    n_xd    = w_lo;
                    n_state = SQ_RED_START;
                end
            end
            SQ_RED_START: begin
                // A zero over zero fraction has no gcd and is reported invalid.
                if (r_xn == '0 && r_xd == '0) begin
                    n_inv   = 1'b1;
                    n_state = SQ_OUT;
                end else begin
                    w_cmd.start = 1'b1;
                    w_cmd.op    = IT_OP_GCD;
                    w_a         = mag(r_xn);
                    w_b         = mag(r_xd);
                    n_state     = SQ_GCD;
                end
            end
            SQ_GCD: begin
                if (w_stat.done) begin
                    n_g         = w_lo;
                    w_cmd.start = 1'b1;
                    w_cmd.op    = IT_OP_DIV;
                    w_a         = mag(r_xn);
                    w_b         = w_lo;
                    n_state     = SQ_DIVN;
                end
            end
            SQ_DIVN: begin
                if (w_stat.done) begin
                    // The sign of the fraction moves to the numerator.
                    n_qn        = (r_xn[W-1] ^ r_xd[W-1]) ? (~w_lo + W'(1)) : w_lo;
                    w_cmd.start = 1'b1;
                    w_cmd.op    = IT_OP_DIV;
                    w_a         = mag(r_xd);
                    w_b         = r_g;
                    n_state     = SQ_DIVD;
                end
            end
            SQ_DIVD: begin
                if (w_stat.done) begin
                    n_qd    = w_lo;
                    n_state = SQ_RED_DONE;
                end
            end
            SQ_RED_DONE: begin
                if (r_mode == MODE_CMP) begin
                    if (!r_pass) begin
                        n_an    = r_qn;
                        n_ad    = r_qd;
                        n_xn    = r_rn;
                        n_xd    = r_rd;
                        n_pass  = 1'b1;
                        n_state = SQ_RED_START;
                    end else begin
                        n_state = SQ_CMP_START;
                    end
                end else begin
                    n_res_n = r_qn;
                    n_res_d = r_qd;
                    n_state = SQ_OUT;
                end
            end
            SQ_CMP_START: begin
                if (r_an == r_qn && r_ad == r_qd) begin
                    n_ord   = ORD_EQ;
                    n_state = SQ_OUT;
                end else if (w_s1 != w_s2) begin
                    n_ord   = (w_s1 > w_s2) ? ORD_GT : ORD_LT;
                    n_state = SQ_OUT;
                end else if (w_s1 == ORD_EQ) begin
                    n_ord   = ORD_LT;
                    n_state = SQ_OUT;
                end else begin
                    // Same nonzero sign: compare |an|*|bd| against |bn|*|ad| exactly.
                    w_cmd.start = 1'b1;
                    w_cmd.op    = IT_OP_MUL;
                    w_a         = mag(r_an);
                    w_b         = mag(r_qd);
                    n_state     = SQ_CMP_M1;
                end
            end
            SQ_CMP_M1: begin
                if (w_stat.done) begin
                    n_p1        = w_p2;
                    w_cmd.start = 1'b1;
                    w_cmd.op    = IT_OP_MUL;
                    w_a         = mag(r_qn);
                    w_b         = mag(r_ad);
                    n_state     = SQ_CMP_M2;
                end
            end
            SQ_CMP_M2: begin
                if (w_stat.done) begin
                    if (w_s1 == ORD_GT) begin
                        n_ord = (r_p1 > w_p2) ? ORD_GT : ORD_LT;
                    end else begin
                        n_ord = (r_p1 < w_p2) ? ORD_GT : ORD_LT;
                    end
                    n_state = SQ_OUT;
                end
            end
            SQ_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_on     = to_field(r_res_n);
                    n_od     = to_field(r_res_d);
                    n_oord   = r_ord;
                    n_oinv   = r_inv;
                    n_state  = SQ_IDLE;
                end
            end
            default: begin
                n_state = SQ_IDLE;
            end
        endcase
    end

    a_accept_unit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> !w_stat.busy)
        else $error("input accepted while the shared unit is still working");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("invalid result carries nonzero data");

    a_order_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_oord != 2'b10))
        else $error("order field holds an unused code");

    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == SQ_OUT))
        else $error("output register loaded outside the output state");

endmodule

// File: design/rarc_iter.sv
module rarc_iter #(
    parameter int WORD_WIDTH = rarc_pkg::RARC_WORD_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rarc_pkg::t_it_cmd      i_cmd,
    input  logic [WORD_WIDTH-1:0]  i_a,
    input  logic [WORD_WIDTH-1:0]  i_b,
    output rarc_pkg::t_it_stat     o_stat,
    output logic [WORD_WIDTH-1:0]  o_hi,
    output logic [WORD_WIDTH-1:0]  o_lo
);
    import rarc_pkg::*;

    localparam int CNT_W = $clog2(WORD_WIDTH);

    t_it_state             r_state, n_state;
    logic [WORD_WIDTH-1:0] r_hi, n_hi;
    logic [WORD_WIDTH-1:0] r_lo, n_lo;
    logic [WORD_WIDTH-1:0] r_m, n_m;
    logic [CNT_W-1:0]      r_cnt, n_cnt;

    logic [WORD_WIDTH:0]   mul_sum;
    logic [WORD_WIDTH:0]   div_t;
    logic [WORD_WIDTH+1:0] div_d;
    logic                  gcd_ge;
    logic [WORD_WIDTH-1:0] gcd_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= IT_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi  <= n_hi;
        r_lo  <= n_lo;
        r_m   <= n_m;
        r_cnt <= n_cnt;
    end

    always_comb begin
        n_state = r_state;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_m     = r_m;
        n_cnt   = r_cnt;

        // Shift-add multiply: the multiplier sits in lo and shifts out as the
        // product's low half shifts in.
        mul_sum  = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_m} : '0);
        // Restoring divide: hi is the partial remainder, lo turns from the
        // dividend into the quotient.
        div_t    = {r_hi, r_lo[WORD_WIDTH-1]};
        div_d    = {1'b0, div_t} - {2'b00, r_m};
        // Binary gcd subtracts the smaller odd operand from the larger.
        gcd_ge   = r_hi >= r_lo;
        gcd_diff = gcd_ge ? (r_hi - r_lo) : (r_lo - r_hi);

        case (r_state)
            IT_IDLE, IT_DONE: begin
                if (i_cmd.start) begin
                    case (i_cmd.op)
                        IT_OP_MUL: begin
                            n_hi    = '0;
                            n_lo    = i_b;
                            n_m     = i_a;
                            n_cnt   = CNT_W'(WORD_WIDTH - 1);
                            n_state = IT_MUL;
                        end
                        IT_OP_DIV: begin
                            n_hi    = '0;
                            n_lo    = i_a;
                            n_m     = i_b;
                            n_cnt   = CNT_W'(WORD_WIDTH - 1);
                            n_state = IT_DIV;
                        end
                        IT_OP_GCD: begin
                            n_hi    = i_a;
                            n_lo    = i_b;
                            n_cnt   = '0;
                            n_state = IT_GCD;
                        end
                        default: begin
                            n_state = IT_IDLE;
                        end
                    endcase
                end else begin
                    n_state = IT_IDLE;
                end
            end
            IT_MUL: begin
                n_hi = mul_sum[WORD_WIDTH:1];
                n_lo = {mul_sum[0], r_lo[WORD_WIDTH-1:1]};
                if (r_cnt == '0) begin
                    n_state = IT_DONE;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            IT_DIV: begin
                if (!div_d[WORD_WIDTH+1]) begin
                    n_hi = div_d[WORD_WIDTH-1:0];
                end else begin
                    n_hi = div_t[WORD_WIDTH-1:0];
                end
                n_lo = {r_lo[WORD_WIDTH-2:0], ~div_d[WORD_WIDTH+1]};
                if (r_cnt == '0) begin
                    n_state = IT_DONE;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            IT_GCD: begin
                if (r_hi == '0) begin
                    n_state = IT_SHL;
                end else if (r_lo == '0) begin
                    n_lo    = r_hi;
                    n_state = IT_SHL;
                end else begin
                    case ({r_hi[0], r_lo[0]})
                        2'b00: begin
                            n_hi  = r_hi >> 1;
                            n_lo  = r_lo >> 1;
                            n_cnt = r_cnt + CNT_W'(1);
                        end
                        2'b01: begin
                            n_hi = r_hi >> 1;
                        end
                        2'b10: begin
                            n_lo = r_lo >> 1;
                        end
                        default: begin
                            if (gcd_ge) begin
                                n_hi = gcd_diff >> 1;
                            end else begin
                                n_lo = gcd_diff >> 1;
                            end
                        end
                    endcase
                end
            end
            IT_SHL: begin
                // Restore the common power of two removed during the search.
                if (r_cnt == '0) begin
                    n_state = IT_DONE;
                end else begin
                    n_lo  = r_lo << 1;
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            default: begin
                n_state = IT_IDLE;
            end
        endcase
    end

    assign o_stat.busy = (r_state != IT_IDLE) && (r_state != IT_DONE);
    assign o_stat.done = (r_state == IT_DONE);
    assign o_hi        = r_hi;
    assign o_lo        = r_lo;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> !o_stat.busy)
        else $error("iterative unit started while busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.done |=> !o_stat.done)
        else $error("done held for more than one cycle");

    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == IT_GCD && n_state == IT_SHL) |-> (n_lo != '0))
        else $error("gcd of two zero operands");

endmodule
